// ===== design/lru_key_value_cache_defines.svh =====
// Assertion macros shared by the lru_key_value_cache checker.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Antecedent (expression or sequence) implies a consequent sequence.
`define LKV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Condition now implies that prior held at an earlier sample, taken with $past.
`define LKV_ASSERT_PAST2(lbl, cond, prior, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> $past(prior, 2)) \
    else $error(msg);

`endif

// ===== design/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int CAP_W  = 5;
  localparam int DATA_W = 32;

  // APB address: one 32-bit register at byte 0, index taken from paddr[2].
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;
  localparam logic signed [VAL_W-1:0] PUT_VALUE  = 32'sd0;

  // What the result stage shows for read_value.
  localparam logic [1:0] KIND_HIT  = 2'd0;
  localparam logic [1:0] KIND_MISS = 2'd1;
  localparam logic [1:0] KIND_PUT  = 2'd2;

  // Tag store -> value RAM / result stage.
  typedef struct packed {
    logic found;
    logic val_we;
    logic val_re;
  } lkv_access_t;

endpackage

// ===== design/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg, lkv_tag_store and lkv_ram.
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// One transaction is a get (in_cmd 0) or a put (in_cmd 1) of a 32-bit key;
// it is accepted on a rising edge with start high and busy low. busy is low
// whenever the block is out of reset, so a transaction may be issued every
// cycle. Each transaction yields exactly one result, shown for one cycle
// with out_valid high, after the request and result registers; results
// leave in order and the receiver cannot stall them. First the request
// is registered; the lookup stage matches it against all keys in parallel,
// updates the recency ranks, valid bits and occupancy, and reads or writes
// the value RAM; the RAM's registered read feeds the result. A get hit
// returns found=1 and the stored value and makes the entry most recent; a
// get miss returns found=0 and -1. A put returns 0, with found telling
// whether the key was present; a present key is overwritten and promoted,
// a new key goes into the lowest free slot after evicting the least recent
// entry once occupancy has reached the capacity. Capacity is a 5-bit
// register at APB byte address 0 (reset 16): zero acts as one, values above
// MAX_ENTRIES act as MAX_ENTRIES, and lowering it never drops entries, a
// new key then just replaces the oldest. Write it only while no
// transaction is in flight. The store is empty after reset with no
// clearing pass.

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_cmd,
  input  logic signed [lkv_pkg::KEY_W-1:0]   in_key,
  input  logic signed [lkv_pkg::VAL_W-1:0]   in_put_value,
  // result channel
  output logic                               out_valid,
  output logic                               out_found,
  output logic signed [lkv_pkg::VAL_W-1:0]   out_read_value,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lkv_pkg::PADDR_W-1:0]        paddr,
  input  logic [lkv_pkg::DATA_W-1:0]         pwdata,
  output logic [lkv_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);

  // ---- configuration ------------------------------------------------------
  logic [lkv_pkg::CAP_W-1:0]     capacity_r;
  logic [lkv_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lkv_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lkv_pkg::CAP_RESET;
    end else if (cfg_wr && (reg_idx == lkv_pkg::REG_CAPACITY)) begin
      capacity_r <= pwdata[lkv_pkg::CAP_W-1:0];
    end
  end

  assign prdata = (reg_idx == lkv_pkg::REG_CAPACITY)
                ? {{(lkv_pkg::DATA_W - lkv_pkg::CAP_W){1'b0}}, capacity_r}
                : '0;

  // ---- request register ---------------------------------------------------
  // Never stalls; busy only covers reset.
  assign busy = !rst_n;

  logic                      in_valid_r;
  logic                      in_cmd_r;
  logic [lkv_pkg::KEY_W-1:0] in_key_r;
  logic [lkv_pkg::VAL_W-1:0] in_val_r;
  logic                      accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd_r <= in_cmd;
      in_key_r <= in_key;
      in_val_r <= in_put_value;
    end
  end

  // ---- lookup / update ----------------------------------------------------
  lkv_pkg::lkv_access_t acc;
  logic [IDX_W-1:0]     slot_idx;

  lkv_tag_store #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_tags (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_valid_r),
    .req_cmd  (in_cmd_r),
    .req_key  (in_key_r),
    .capacity (capacity_r),
    .acc      (acc),
    .idx      (slot_idx)
  );

  // Values live in RAM: a put writes its slot, a get hit reads it; the
  // registered read lines up with the result stage.
  logic [lkv_pkg::VAL_W-1:0] ram_rdata;

  lkv_ram #(
    .WIDTH(lkv_pkg::VAL_W),
    .DEPTH(MAX_ENTRIES)
  ) u_values (
    .clk  (clk),
    .we   (acc.val_we),
    .re   (acc.val_re),
    .addr (slot_idx),
    .wdata(in_val_r),
    .rdata(ram_rdata)
  );

  // ---- result stage -------------------------------------------------------
  logic       out_valid_r;
  logic       out_found_r;
  logic [1:0] out_kind_r, out_kind_nxt;

  always_comb begin
    if (in_cmd_r == lkv_pkg::CMD_PUT) begin
      out_kind_nxt = lkv_pkg::KIND_PUT;
    end else if (acc.found) begin
      out_kind_nxt = lkv_pkg::KIND_HIT;
    end else begin
      out_kind_nxt = lkv_pkg::KIND_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_found_r <= acc.found;
      out_kind_r  <= out_kind_nxt;
    end
  end

  always_comb begin
    case (out_kind_r)
      lkv_pkg::KIND_HIT:  out_read_value = $signed(ram_rdata);
      lkv_pkg::KIND_MISS: out_read_value = lkv_pkg::MISS_VALUE;
      lkv_pkg::KIND_PUT:  out_read_value = lkv_pkg::PUT_VALUE;
      default:            out_read_value = lkv_pkg::PUT_VALUE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule

// ===== design/lkv_ram.sv =====
// Generic single-port RAM, one access per cycle, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/lkv_tag_store.sv =====
// Key, valid, recency and occupancy state with the parallel key match.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_tag_store #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
  localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  input  logic                      req_cmd,
  input  logic [lkv_pkg::KEY_W-1:0] req_key,
  input  logic [lkv_pkg::CAP_W-1:0] capacity,
  output lkv_pkg::lkv_access_t      acc,
  output logic [IDX_W-1:0]          idx
);

  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

  logic [lkv_pkg::KEY_W-1:0] key_r   [MAX_ENTRIES];
  logic [IDX_W-1:0]          rank_r  [MAX_ENTRIES];
  logic [IDX_W-1:0]          rank_nxt[MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]    valid_r, valid_nxt;
  logic [OCC_W-1:0]          occ_r, occ_nxt;

  logic [MAX_ENTRIES-1:0] hit_vec, victim_vec, valid_kept, free_vec, free_oh;
  logic                   hit, full, evict, is_put;
  logic [IDX_W-1:0]       hit_idx, hit_rank, free_idx, oldest_rank;
  logic [OCC_W-1:0]       occ_m1;
  logic [CMP_W-1:0]       cap_ext, eff_cap;

  always_comb begin
    hit_vec  = '0;
    hit_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == req_key);
      if (hit_vec[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | rank_r[i];
      end
    end
    hit = |hit_vec;
  end

  // Valid ranks are always a permutation of 0..occ-1, so the LRU entry
  // is the one whose rank equals occ-1.
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    full        = CMP_W'(occ_r) >= eff_cap;
    occ_m1      = occ_r - OCC_W'(1);
    oldest_rank = occ_m1[IDX_W-1:0];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      victim_vec[i] = valid_r[i] && (rank_r[i] == oldest_rank);
    end
  end

  assign is_put     = req_valid && (req_cmd == lkv_pkg::CMD_PUT);
  assign evict      = is_put && !hit && full;
  assign valid_kept = evict ? (valid_r & ~victim_vec) : valid_r;
  assign free_vec   = ~valid_kept;
  assign free_oh    = free_vec & (~free_vec + MAX_ENTRIES'(1));

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (free_oh[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (req_valid && hit) begin
      // promote: younger entries age by one
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
      rank_nxt[hit_idx] = '0;
    end else if (is_put) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_kept[i]) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
      rank_nxt[free_idx] = '0;
      valid_nxt          = valid_kept | free_oh;
      occ_nxt            = evict ? occ_r : occ_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // keys carry no reset; valid bits gate every compare
  always_ff @(posedge clk) begin
    if (is_put && !hit) begin
      key_r[free_idx] <= req_key;
    end
  end

  assign acc.found  = hit;
  assign acc.val_we = is_put;
  assign acc.val_re = req_valid && (req_cmd == lkv_pkg::CMD_GET) && hit;
  assign idx        = hit ? hit_idx : free_idx;

endmodule

// ===== design/lkv_checker.sv =====
// Port-level checker for lru_key_value_cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache_defines.svh.
`timescale 1ns / 1ps
`include "lru_key_value_cache_defines.svh"

module lkv_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             in_cmd,
  input logic signed [lkv_pkg::KEY_W-1:0] in_key,
  input logic                             out_valid,
  input logic                             out_found,
  input logic signed [lkv_pkg::VAL_W-1:0] out_read_value
);

  // every accepted transaction gets its result after the request and result registers
  `LKV_ASSERT_IMPL(a_result_follows, start && !busy, ##2 out_valid, "missing result")

  // no result without a matching accepted transaction before it
  `LKV_ASSERT_PAST2(a_no_spurious, out_valid, start && !busy, "result without request")

  // a miss shows -1 (get) or 0 (put)
  `LKV_ASSERT_IMPL(a_miss_value, out_valid && !out_found, (out_read_value == lkv_pkg::MISS_VALUE || out_read_value == lkv_pkg::PUT_VALUE), "bad miss value")

  // a get right after a put of the same key must hit
  `LKV_ASSERT_IMPL(a_put_then_get, (start && !busy && in_cmd == lkv_pkg::CMD_PUT) ##1 (start && !busy && in_cmd == lkv_pkg::CMD_GET && in_key == $past(in_key)), ##2 out_found, "get after put missed")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

// ===== dv/lkv_cache_sb_pkg.sv =====
// Scoreboard for the LRU key-value cache bench: a copy of the store and the
// queue of expected lookup results. Depends on lkv_pkg.
`timescale 1ns / 1ps

package lkv_cache_sb_pkg;
  import lkv_pkg::*;

  localparam int DEPTH = MAX_ENTRIES_DEF;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } lookup_t;

  class lkv_cache_scoreboard;
    logic [KEY_W-1:0] slot_key [DEPTH];
    logic [VAL_W-1:0] slot_val [DEPTH];
    bit               slot_live [DEPTH];
    int unsigned      slot_age [DEPTH];   // 0 = most recent
    int unsigned      fill;
    logic [CAP_W-1:0] capacity;
    lookup_t          lookup_q [$];
    int unsigned      fail_count;

    function new();
      int i;
      for (i = 0; i < DEPTH; i++) begin
        slot_key[i]  = '0;
        slot_val[i]  = '0;
        slot_live[i] = 1'b0;
        slot_age[i]  = 0;
      end
      fill       = 0;
      capacity   = CAP_RESET;
      fail_count = 0;
    endfunction

    function void set_capacity(logic [DATA_W-1:0] data);
      capacity = data[CAP_W-1:0];
    endfunction

    // zero acts as one, anything past the built depth saturates
    function int unsigned usable_slots();
      if (capacity == 0) return 1;
      if (capacity > DEPTH) return DEPTH;
      return 32'(capacity);
    endfunction

    function int unsigned outstanding();
      return lookup_q.size();
    endfunction

    function void make_newest(int s);
      int i;
      int unsigned r;
      r = slot_age[s];
      for (i = 0; i < DEPTH; i++)
        if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    // Apply one accepted get/put and queue the result it must produce.
    function void note_request(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      int      i;
      int      hit;
      int      victim;
      int      free_slot;
      lookup_t res;
      hit = -1;
      for (i = 0; i < DEPTH; i++)
        if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;

      if (cmd == CMD_GET) begin
        if (hit >= 0) begin
          make_newest(hit);
          res.found      = 1'b1;
          res.read_value = slot_val[hit];
        end else begin
          res.found      = 1'b0;
          res.read_value = MISS_VALUE;
        end
      end else begin
        res.found      = (hit >= 0);
        res.read_value = PUT_VALUE;
        if (hit >= 0) begin
          slot_val[hit] = value;
          make_newest(hit);
        end else begin
          // full (or over a lowered capacity): drop exactly one, the oldest
          if (fill >= usable_slots()) begin
            victim = -1;
            for (i = 0; i < DEPTH; i++)
              if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
            if (victim >= 0) begin
              slot_live[victim] = 1'b0;
              slot_age[victim]  = 0;
              if (fill > 0) fill--;
            end
          end
          free_slot = -1;
          for (i = 0; i < DEPTH; i++)
            if (free_slot < 0 && !slot_live[i]) free_slot = i;
          if (free_slot >= 0) begin
            for (i = 0; i < DEPTH; i++)
              if (slot_live[i]) slot_age[i]++;
            slot_key[free_slot]  = key;
            slot_val[free_slot]  = value;
            slot_live[free_slot] = 1'b1;
            slot_age[free_slot]  = 0;
            fill++;
          end
        end
      end
      lookup_q.push_back(res);
    endfunction

    function void check_result(logic found, logic [VAL_W-1:0] read_value);
      lookup_t exp_res;
      if (lookup_q.size() == 0) begin
        $error("result strobe with no transaction pending");
        fail_count++;
        return;
      end
      exp_res = lookup_q.pop_front();
      if (found !== exp_res.found) begin
        $error("found: expected %0d, actual %0d", exp_res.found, found);
        fail_count++;
      end
      if (read_value !== exp_res.read_value) begin
        $error("read_value: expected %h, actual %h", exp_res.read_value, read_value);
        fail_count++;
      end
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
// Top of the LRU key-value cache bench: clock, reset, command/APB drivers
// and the result monitor. Depends on lkv_pkg, lkv_cache_sb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import lkv_pkg::*;
  import lkv_cache_sb_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_cmd;
  logic signed [KEY_W-1:0] in_key;
  logic signed [VAL_W-1:0] in_put_value;
  logic                    out_valid;
  logic                    out_found;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  lkv_cache_scoreboard sb = new();

  always #6 clk = ~clk;

  lru_key_value_cache u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_put_value   (in_put_value),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Results cannot be stalled: every strobe is a finished transaction.
  // Sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_found, out_read_value);
  end

  // Hard stop; a correct run finishes far earlier.
  initial begin
    #10ms;
    $display("lru_key_value_cache regression: fail");
    $finish;
  end

  // All drivers below are entered and left at a falling edge.

  // One get/put transaction: hold start until busy is seen low at an edge.
  task automatic issue(input logic cmd, input logic [KEY_W-1:0] key,
                       input logic [VAL_W-1:0] value);
    start        = 1'b1;
    in_cmd       = cmd;
    in_key       = key;
    in_put_value = value;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(cmd, key, value);
    @(negedge clk);
  endtask

  // Sender gap; the payload wiggles meanwhile since it must be ignored.
  task automatic idle(input int unsigned cycles);
    start        = 1'b0;
    in_cmd       = 1'($urandom);
    in_key       = $urandom;
    in_put_value = $urandom;
    repeat (cycles) @(negedge clk);
  endtask

  // Hold off until every outstanding transaction has produced its result.
  // Each transaction yields one result, so an empty queue means idle.
  task automatic drain();
    start = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    drain();
    // setup, then access; the write lands at the edge closing the access
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'({REG_CAPACITY, 2'b00});
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_capacity(data);
    @(negedge clk);
    // read it back: only the 5-bit field is kept
    penable = 1'b0;
    pwrite  = 1'b0;
    pwdata  = $urandom;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd !== DATA_W'(sb.capacity)) begin
      $error("capacity: expected %h, actual %h", DATA_W'(sb.capacity), rd);
      sb.fail_count++;
    end
  endtask

  // Mostly back-to-back, some short gaps, an occasional long one.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned p;
    if (quiet) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    if (p < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  initial begin
    logic [KEY_W-1:0]  key_pool [$];
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] cap_word;
    logic              cmd;
    int unsigned       cap;
    int unsigned       pool_len;
    int unsigned       gap;
    int unsigned       pick;
    bit                quiet;
    int                phase;
    int                n;
    int                i;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = CMD_GET;
    in_key       = '0;
    in_put_value = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed: empty store, key/value extremes, hits, update --------
    issue(CMD_GET, 32'h0000_0000, $urandom);       // miss on empty store
    issue(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    issue(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    issue(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    issue(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    issue(CMD_GET, 32'h8000_0000, $urandom);
    issue(CMD_GET, 32'h7FFF_FFFF, $urandom);
    issue(CMD_GET, 32'hFFFF_FFFF, $urandom);
    issue(CMD_PUT, 32'h0000_0000, 32'h1234_5678);  // overwrite, promote
    issue(CMD_GET, 32'h0000_0000, $urandom);
    issue(CMD_GET, 32'h0000_0001, $urandom);       // near miss
    issue(CMD_GET, 32'hAAAA_AAAA, $urandom);
    // capacity lowered below occupancy: each new key swaps out one oldest
    write_capacity(DATA_W'(2));
    issue(CMD_PUT, 32'h0BAD_F00D, 32'h0F0F_0F0F);  // evicts the oldest
    issue(CMD_GET, 32'h8000_0000, $urandom);       // still present: 5555_5555 was the oldest
    issue(CMD_PUT, 32'h1357_9BDF, 32'hF0F0_F0F0);
    issue(CMD_GET, 32'h0BAD_F00D, $urandom);
    issue(CMD_PUT, 32'h5555_5555, 32'h0000_0001);  // evicted earlier: inserted anew, evicts the oldest
    issue(CMD_GET, 32'h5555_5555, $urandom);
    // zero behaves as one, above the depth saturates
    write_capacity(DATA_W'(0));
    issue(CMD_PUT, 32'hCAFE_0001, 32'h0000_0002);
    issue(CMD_GET, 32'hCAFE_0001, $urandom);
    write_capacity(32'hFFFF_FFFF);                  // field reads 31
    issue(CMD_PUT, 32'hCAFE_0002, 32'h0000_0003);
    issue(CMD_GET, 32'hCAFE_0001, $urandom);

    // ---- random phases, one capacity setting each -----------------------
    // Keys mostly come from a pool a bit larger than the capacity, so puts
    // and gets hit, update and evict; a share of fresh keys is noise.
    // The fill at 16 followed by 3 drives eviction over a lowered capacity.
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: cap = 1;
        1: cap = 0;
        2: cap = 16;
        3: cap = 3;
        4: cap = 31;
        5: cap = 17;
        6: cap = 2;
        7: cap = 8;
        default: cap = $urandom_range(31);
      endcase
      if ($urandom_range(1)) cap_word = ($urandom & 32'hFFFF_FFE0) | DATA_W'(cap);
      else cap_word = DATA_W'(cap);
      write_capacity(cap_word);

      key_pool.delete();
      pool_len = sb.usable_slots() + $urandom_range(6, 1);
      for (i = 0; i < pool_len; i++) begin
        pick = $urandom_range(9);
        case (pick)
          0: key_pool.push_back(32'h8000_0000);
          1: key_pool.push_back(32'h7FFF_FFFF);
          2: key_pool.push_back(32'hFFFF_FFFF);
          3: key_pool.push_back(32'h0000_0000);
          default: key_pool.push_back($urandom);
        endcase
      end

      quiet = 1'b0;
      for (n = 0; n < 200; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(3) == 0);  // burst mode
        gap = pick_gap(quiet);
        if (gap != 0) idle(gap);
        if ($urandom_range(99) < 12) key = $urandom;
        else key = key_pool[$urandom_range(key_pool.size() - 1)];
        cmd = ($urandom_range(99) < 45) ? CMD_PUT : CMD_GET;
        issue(cmd, key, $urandom);
        if ($urandom_range(149) == 0) drain();
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("lru_key_value_cache regression: pass");
    end else begin
      $display("lru_key_value_cache regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/lkv_pkg.sv
design/lkv_ram.sv
design/lkv_tag_store.sv
design/lru_key_value_cache.sv
design/lkv_checker.sv
dv/lkv_cache_sb_pkg.sv
dv/tb_top.sv
